// ===== sv/bottom_up_heap_sorter_assert.svh =====
// Assertion macros shared by the heap sorter RTL.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef BOTTOM_UP_HEAP_SORTER_ASSERT_SVH
`define BOTTOM_UP_HEAP_SORTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define BHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define BHS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BHS_ASSERT(label, prop, msg)
`define BHS_NEVER(label, cond, msg)
`endif

`endif

// ===== sv/bhs_pkg.sv =====
// Package for the bottom-up heap sorter: item structs, state encodings
// and the sequencer status group. No dependencies.
package bhs_pkg;

  localparam int WORD_W = 32;

  // Input item: one element of the set
  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     last;
  } in_item_t;

  // Result item: one sorted element
  typedef struct packed {
    logic signed [WORD_W-1:0] sorted_value;
    logic                     last_res;
    logic                     overflow;
  } out_item_t;

  // Top-level control: load, sort, emit
  typedef enum logic [3:0] {
    T_LOAD = 4'b0001,
    T_SORT = 4'b0010,
    T_ELD  = 4'b0100,
    T_EOUT = 4'b1000
  } top_state_e;

  // Heap sequencer states
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_TOP   = 8'b0000_0010,
    S_TOPV  = 8'b0000_0100,
    S_SWAP  = 8'b0000_1000,
    S_SWAPV = 8'b0001_0000,
    S_DESC  = 8'b0010_0000,
    S_CLIMB = 8'b0100_0000,
    S_ROT   = 8'b1000_0000
  } seq_state_e;

  // Sequencer status towards the top level
  typedef struct packed {
    logic busy;
    logic done;
  } seq_status_t;

endpackage

// ===== sv/bottom_up_heap_sorter.sv =====
// Top level of the bottom-up heap sorter: input loading, result emission
// and store port sharing. Depends on bhs_pkg, bhs_mem, bhs_seq and the macros.
//
// Use: send elements on the input channel (in_valid_i, in_stall_o,
// in_item_i); each item carries a signed value and a last flag. Up to
// DEPTH elements are kept; further ones are dropped and mark the set as
// overflowed. The item flagged last starts the sort, and in_stall_o stays
// high until every result of the set has been taken.
// Results leave on the output channel (out_valid_o, out_stall_i,
// out_item_o) in ascending order, last_res on the final one, overflow on
// all of them. A result holds while out_stall_i is high.
// Loading accepts one element per cycle while in_stall_o is low; a registered
// start then hands the set over to the sequencer. A sift fetches the top
// value, descends one level at a time along the larger child, then climbs
// and rotates the path; a sift at a leaf goes straight to the rotation.
// Each result is read from the store, then held in the output register.
// Reset clears the element count, overflow flag and all control; store
// contents are not cleared and need no clearing pass.
`include "bottom_up_heap_sorter_assert.svh"

module bottom_up_heap_sorter #(
  parameter int DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bhs_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bhs_pkg::out_item_t  out_item_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bhs_pkg::top_state_e state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [AW-1:0]       k_q, k_d;
  logic                start_q, start_d;
  bhs_pkg::out_item_t  out_q, out_d;

  logic                accept;
  logic                top_we;
  logic [AW-1:0]       top_wa;
  logic [AW-1:0]       top_ra;

  bhs_pkg::seq_status_t              seq_status;
  logic [AW-1:0]                     seq_ra_a, seq_ra_b;
  logic                              seq_we;
  logic [AW-1:0]                     seq_wa;
  logic signed [bhs_pkg::WORD_W-1:0] seq_wd;

  logic                              mem_we;
  logic [AW-1:0]                     mem_wa;
  logic signed [bhs_pkg::WORD_W-1:0] mem_wd;
  logic [AW-1:0]                     mem_ra_a;
  logic signed [bhs_pkg::WORD_W-1:0] mem_rd_a, mem_rd_b;

  assign in_stall_o  = (state_q != bhs_pkg::T_LOAD);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == bhs_pkg::T_EOUT);
  assign out_item_o  = out_q;

  // Load, hand over to the sequencer, emit
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    k_d     = k_q;
    start_d = 1'b0;
    out_d   = out_q;
    top_we  = 1'b0;
    top_wa  = count_q[AW-1:0];
    top_ra  = k_q;
    unique case (state_q)
      bhs_pkg::T_LOAD: begin
        if (accept) begin
          if (count_q < CW'(DEPTH)) begin
            top_we  = 1'b1;
            count_d = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_item_i.last) begin
            start_d = 1'b1;
            state_d = bhs_pkg::T_SORT;
          end
        end
      end
      bhs_pkg::T_SORT: begin
        if (seq_status.done) begin
          top_ra  = '0;
          k_d     = '0;
          state_d = bhs_pkg::T_ELD;
        end
      end
      bhs_pkg::T_ELD: begin
        out_d.sorted_value = mem_rd_a;
        out_d.last_res     = ((CW'(k_q) + CW'(1)) == count_q);
        out_d.overflow     = ovf_q;
        state_d            = bhs_pkg::T_EOUT;
      end
      bhs_pkg::T_EOUT: begin
        if (!out_stall_i) begin
          if (out_q.last_res) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = bhs_pkg::T_LOAD;
          end else begin
            k_d     = k_q + AW'(1);
            top_ra  = k_q + AW'(1);
            state_d = bhs_pkg::T_ELD;
          end
        end
      end
      default: begin
        state_d = bhs_pkg::T_LOAD;
      end
    endcase
  end

  // Share the store ports: sequencer owns them while sorting (read a until done)
  assign mem_we   = (state_q == bhs_pkg::T_SORT) ? seq_we : top_we;
  assign mem_wa   = (state_q == bhs_pkg::T_SORT) ? seq_wa : top_wa;
  assign mem_wd   = (state_q == bhs_pkg::T_SORT) ? seq_wd : in_item_i.value;
  assign mem_ra_a = ((state_q == bhs_pkg::T_SORT) && !seq_status.done) ? seq_ra_a : top_ra;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bhs_pkg::T_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
      k_q     <= '0;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      k_q     <= k_d;
      start_q <= start_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  bhs_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i       (clk_i),
    .wr_en_i     (mem_we),
    .wr_addr_i   (mem_wa),
    .wr_data_i   (mem_wd),
    .rd_addr_a_i (mem_ra_a),
    .rd_addr_b_i (seq_ra_b),
    .rd_data_a_o (mem_rd_a),
    .rd_data_b_o (mem_rd_b)
  );

  bhs_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_q),
    .count_i     (count_q),
    .status_o    (seq_status),
    .rd_addr_a_o (seq_ra_a),
    .rd_addr_b_o (seq_ra_b),
    .rd_data_a_i (mem_rd_a),
    .rd_data_b_i (mem_rd_b),
    .wr_en_o     (seq_we),
    .wr_addr_o   (seq_wa),
    .wr_data_o   (seq_wd)
  );

  `BHS_ASSERT(a_count_range, count_q <= CW'(DEPTH), "element count above depth")
  `BHS_ASSERT(a_load_seq_idle, (state_q == bhs_pkg::T_LOAD) |-> !seq_status.busy,
              "sequencer busy while loading")
  `BHS_ASSERT(a_emit_nonempty, out_valid_o |-> (count_q != '0), "result from an empty set")
  `BHS_NEVER(a_seq_write_outside_sort, seq_we && (state_q != bhs_pkg::T_SORT),
             "sequencer write outside sort")

endmodule

// ===== sv/bhs_mem.sv =====
// Element store of the heap sorter: one write port, two registered read ports.
// Depends on bhs_pkg for the word width.
module bhs_mem #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                                 clk_i,
  input  logic                                 wr_en_i,
  input  logic [AW-1:0]                        wr_addr_i,
  input  logic signed [bhs_pkg::WORD_W-1:0]    wr_data_i,
  input  logic [AW-1:0]                        rd_addr_a_i,
  input  logic [AW-1:0]                        rd_addr_b_i,
  output logic signed [bhs_pkg::WORD_W-1:0]    rd_data_a_o,
  output logic signed [bhs_pkg::WORD_W-1:0]    rd_data_b_o
);

  logic signed [bhs_pkg::WORD_W-1:0] mem_q [DEPTH];

  // Write, then register both reads (new data forwarded on a same-address collision)
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_a_o <= (wr_en_i && (wr_addr_i == rd_addr_a_i)) ? wr_data_i : mem_q[rd_addr_a_i];
    rd_data_b_o <= (wr_en_i && (wr_addr_i == rd_addr_b_i)) ? wr_data_i : mem_q[rd_addr_b_i];
  end

endmodule

// ===== sv/bhs_seq.sv =====
// Heap sequencer: runs bottom-up heapsort on the element store in place.
// Depends on bhs_pkg and the assertion macro header.
`include "bottom_up_heap_sorter_assert.svh"

module bhs_seq #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [CW-1:0]                     count_i,
  output bhs_pkg::seq_status_t              status_o,
  output logic [AW-1:0]                     rd_addr_a_o,
  output logic [AW-1:0]                     rd_addr_b_o,
  input  logic signed [bhs_pkg::WORD_W-1:0] rd_data_a_i,
  input  logic signed [bhs_pkg::WORD_W-1:0] rd_data_b_i,
  output logic                              wr_en_o,
  output logic [AW-1:0]                     wr_addr_o,
  output logic signed [bhs_pkg::WORD_W-1:0] wr_data_o
);

  localparam int IW = AW + 1;

  bhs_pkg::seq_state_e state_q, state_d;
  logic                sort_q, sort_d;
  logic [AW-1:0]       i_q, i_d;
  logic [AW-1:0]       top_q, top_d;
  logic [AW-1:0]       j_q, j_d;
  logic [CW-1:0]       end_q, end_d;
  logic [CW-1:0]       n_q, n_d;
  logic signed [bhs_pkg::WORD_W-1:0] topval_q, topval_d;
  logic signed [bhs_pkg::WORD_W-1:0] carry_q, carry_d;

  logic [IW-1:0] end_w;
  logic [IW-1:0] top_left, top_right;
  logic [IW-1:0] j_left, j_right;
  logic          take_right;
  logic [AW-1:0] pick;
  logic [IW-1:0] pick_left, pick_right;
  logic [AW-1:0] parent_j;
  logic          done;

  // Child and parent indices of the current path position
  assign end_w      = IW'(end_q);
  assign top_left   = {top_q, 1'b1};
  assign top_right  = top_left + IW'(1);
  assign j_left     = {j_q, 1'b1};
  assign j_right    = j_left + IW'(1);
  assign take_right = (j_right < end_w) && (rd_data_b_i > rd_data_a_i);
  assign pick       = take_right ? j_right[AW-1:0] : j_left[AW-1:0];
  assign pick_left  = {pick, 1'b1};
  assign pick_right = pick_left + IW'(1);
  assign parent_j   = (j_q - AW'(1)) >> 1;

  // Step through build, swap, descent, climb and rotation
  always_comb begin
    state_d     = state_q;
    sort_d      = sort_q;
    i_d         = i_q;
    top_d       = top_q;
    j_d         = j_q;
    end_d       = end_q;
    n_d         = n_q;
    topval_d    = topval_q;
    carry_d     = carry_q;
    rd_addr_a_o = j_q;
    rd_addr_b_o = j_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = j_q;
    wr_data_o   = carry_q;
    done        = 1'b0;
    unique case (state_q)
      bhs_pkg::S_IDLE: begin
        if (start_i) begin
          n_d     = count_i;
          end_d   = count_i;
          i_d     = AW'((count_i - CW'(1)) >> 1);
          top_d   = AW'((count_i - CW'(1)) >> 1);
          sort_d  = 1'b0;
          state_d = bhs_pkg::S_TOP;
        end
      end
      bhs_pkg::S_TOP: begin
        rd_addr_a_o = top_q;
        j_d         = top_q;
        state_d     = bhs_pkg::S_TOPV;
      end
      bhs_pkg::S_TOPV: begin
        topval_d = rd_data_a_i;
        carry_d  = rd_data_a_i;
        if (top_left < end_w) begin
          rd_addr_a_o = top_left[AW-1:0];
          rd_addr_b_o = top_right[AW-1:0];
          state_d     = bhs_pkg::S_DESC;
        end else begin
          state_d = bhs_pkg::S_ROT;
        end
      end
      bhs_pkg::S_SWAP: begin
        rd_addr_a_o = '0;
        rd_addr_b_o = i_q;
        top_d       = '0;
        j_d         = '0;
        state_d     = bhs_pkg::S_SWAPV;
      end
      bhs_pkg::S_SWAPV: begin
        // move the root to the end, sift the old end value from the root
        wr_en_o   = 1'b1;
        wr_addr_o = i_q;
        wr_data_o = rd_data_a_i;
        topval_d  = rd_data_b_i;
        carry_d   = rd_data_b_i;
        if (top_left < end_w) begin
          rd_addr_a_o = top_left[AW-1:0];
          rd_addr_b_o = top_right[AW-1:0];
          state_d     = bhs_pkg::S_DESC;
        end else begin
          state_d = bhs_pkg::S_ROT;
        end
      end
      bhs_pkg::S_DESC: begin
        j_d = pick;
        if (pick_left < end_w) begin
          rd_addr_a_o = pick_left[AW-1:0];
          rd_addr_b_o = pick_right[AW-1:0];
        end else begin
          rd_addr_a_o = pick;
          state_d     = bhs_pkg::S_CLIMB;
        end
      end
      bhs_pkg::S_CLIMB: begin
        if ((j_q > top_q) && (topval_q > rd_data_a_i)) begin
          j_d         = parent_j;
          rd_addr_a_o = parent_j;
        end else begin
          rd_addr_a_o = j_q;
          state_d     = bhs_pkg::S_ROT;
        end
      end
      bhs_pkg::S_ROT: begin
        // write the carried value, pick up the old one, move to the parent; at the sift top, end the sift
        wr_en_o   = 1'b1;
        wr_addr_o = j_q;
        wr_data_o = carry_q;
        if (j_q == top_q) begin
          if (!sort_q) begin
            if (i_q == '0) begin
              if (n_q == CW'(1)) begin
                done    = 1'b1;
                state_d = bhs_pkg::S_IDLE;
              end else begin
                sort_d  = 1'b1;
                i_d     = AW'(n_q - CW'(1));
                end_d   = n_q - CW'(1);
                state_d = bhs_pkg::S_SWAP;
              end
            end else begin
              i_d     = i_q - AW'(1);
              top_d   = i_q - AW'(1);
              state_d = bhs_pkg::S_TOP;
            end
          end else begin
            if (i_q == AW'(1)) begin
              done    = 1'b1;
              state_d = bhs_pkg::S_IDLE;
            end else begin
              i_d     = i_q - AW'(1);
              end_d   = CW'(i_q) - CW'(1);
              state_d = bhs_pkg::S_SWAP;
            end
          end
        end else begin
          carry_d     = rd_data_a_i;
          j_d         = parent_j;
          rd_addr_a_o = parent_j;
        end
      end
      default: begin
        state_d = bhs_pkg::S_IDLE;
      end
    endcase
  end

  assign status_o.busy = (state_q != bhs_pkg::S_IDLE);
  assign status_o.done = done;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bhs_pkg::S_IDLE;
      sort_q  <= 1'b0;
      i_q     <= '0;
      top_q   <= '0;
      j_q     <= '0;
      end_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      sort_q  <= sort_d;
      i_q     <= i_d;
      top_q   <= top_d;
      j_q     <= j_d;
      end_q   <= end_d;
      n_q     <= n_d;
    end
  end

  // Held values of the sift
  always_ff @(posedge clk_i) begin
    topval_q <= topval_d;
    carry_q  <= carry_d;
  end

  `BHS_ASSERT(a_wr_in_set, wr_en_o |-> (CW'(wr_addr_o) < n_q), "sort write beyond set")
  `BHS_ASSERT(a_path_below_top, (state_q == bhs_pkg::S_CLIMB || state_q == bhs_pkg::S_ROT) |-> (j_q >= top_q), "path above sift top")
  `BHS_ASSERT(a_done_pulse, status_o.done |=> !status_o.done, "done longer than a cycle")

endmodule
